### rtl/lspfd_pkg.sv
package lspfd_pkg;

  // Storage and field sizes.
  localparam int MAX_COLS   = 1024;
  localparam int SCORE_BITS = 20;
  localparam int TRANS_BITS = 20;
  localparam int CNT_W      = 11;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CMP_W  = ($clog2(MAX_COLS + 1) > CNT_W) ? $clog2(MAX_COLS + 1) : CNT_W;
  localparam int WIDE_W = ((SCORE_BITS > TRANS_BITS) ? SCORE_BITS : TRANS_BITS) + 2;

  localparam int S_TDATA_W = ((SCORE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((3 * SCORE_BITS + 7) / 8) * 8;

  // Log-sum-exp correction: applied while the operand gap is below CORR_LIMIT,
  // indexed by the gap shifted right by CORR_SHIFT.
  localparam int CORR_LIMIT = 2048;
  localparam int CORR_SHIFT = 6;
  localparam int CORR_IDX_W = 5;

  localparam logic [7:0] CORR_TAB [32] = '{
    8'd177, 8'd147, 8'd121, 8'd99, 8'd80, 8'd64, 8'd52, 8'd41,
    8'd32,  8'd26,  8'd20,  8'd16, 8'd12, 8'd10, 8'd8,  8'd6,
    8'd5,   8'd4,   8'd3,   8'd2,  8'd2,  8'd1,  8'd1,  8'd1,
    8'd1,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic signed [TRANS_BITS-1:0] trans_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic [COL_W-1:0]             col_t;

  // The most negative code stands for log zero.
  localparam score_t VAL_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam score_t VAL_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_COUNT = 3'd0,
    REG_TRANS_MD  = 3'd1,
    REG_TRANS_DD  = 3'd2,
    REG_TRANS_MI  = 3'd3,
    REG_TRANS_II  = 3'd4
  } cfg_reg_t;

  // One cell's three state values; also one row-memory entry.
  typedef struct packed {
    score_t m;
    score_t d;
    score_t i;
  } triple_t;

  localparam triple_t LZ3 = '{m: VAL_MIN, d: VAL_MIN, i: VAL_MIN};

  // Per-cell bookkeeping that follows the cell down the pipeline.
  typedef struct packed {
    col_t   col;
    logic   first_row;
    logic   first_cell;
    logic   last;
    score_t score;
  } cell_tag_t;

  typedef struct packed {
    triple_t fwd;
    logic    last;
  } result_t;

  // Occupancy of the pipeline, used by the hazard check at the input.
  typedef struct packed {
    logic ld1;
    logic s1_valid;
    col_t s1_col;
    logic s2_valid;
    col_t s2_col;
    logic s3_valid;
    col_t s3_col;
    logic s3_leave;
  } pipe_status_t;

  function automatic score_t sat_w(input wide_t x);
    score_t r;
    if (x > wide_t'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (x < wide_t'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = score_t'(x);
    end
    return r;
  endfunction

  function automatic score_t add_sat(input score_t a, input score_t b);
    return sat_w(wide_t'(a) + wide_t'(b));
  endfunction

  // Add a transition; log zero stays log zero.
  function automatic score_t add_lz(input score_t v, input trans_t t);
    score_t r;
    if (v == VAL_MIN) begin
      r = VAL_MIN;
    end else begin
      r = sat_w(wide_t'(v) + wide_t'(t));
    end
    return r;
  endfunction

  // Two-way log-sum-exp: max plus a table correction; log zero operands drop out.
  function automatic score_t lse2(input score_t a, input score_t b);
    wide_t  aw;
    wide_t  bw;
    wide_t  mx;
    wide_t  d;
    score_t r;
    aw = wide_t'(a);
    bw = wide_t'(b);
    mx = (aw > bw) ? aw : bw;
    d  = (aw > bw) ? (aw - bw) : (bw - aw);
    if (d < wide_t'(CORR_LIMIT)) begin
      mx = mx + wide_t'(CORR_TAB[d[CORR_IDX_W+CORR_SHIFT-1:CORR_SHIFT]]);
    end
    if (a == VAL_MIN) begin
      r = b;
    end else if (b == VAL_MIN) begin
      r = a;
    end else begin
      r = sat_w(mx);
    end
    return r;
  endfunction

endpackage

### rtl/lspfd_row_mem.sv
module lspfd_row_mem
  import lspfd_pkg::*;
(
  input  logic    clk,
  input  logic    rd_en,
  input  col_t    rd_addr,
  output triple_t rd_data,
  input  logic    wr_en,
  input  col_t    wr_addr,
  input  triple_t wr_data
);

  // Previous row of M, D and I values, one entry per column.
  triple_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/lspfd_cell_pipe.sv
module lspfd_cell_pipe
  import lspfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         acc,
  input  cell_tag_t    acc_tag,
  input  triple_t      rd_data,
  input  trans_t       trans_md,
  input  trans_t       trans_dd,
  input  trans_t       trans_mi,
  input  trans_t       trans_ii,
  input  logic         res_ready,
  output pipe_status_t status,
  output logic         res_valid,
  output result_t      res,
  output logic         wr_en,
  output col_t         wr_addr,
  output triple_t      wr_data
);

  logic      s1_valid, s2_valid, s3_valid;
  cell_tag_t s1_tag, s2_tag, s3_tag;
  triple_t   s2_u;
  score_t    s3_p, s3_q, s3_nd;

  triple_t   diag, left;
  logic      wb_valid;
  col_t      wb_addr;
  triple_t   wb_data;

  logic      ld_res, ld3, ld2, ld1;
  triple_t   u_fwd, u1;
  triple_t   dg;
  score_t    p_c, q_c, nd_c;
  score_t    lm, li, nm, ni;

  assign ld_res = !res_valid || res_ready;
  assign ld3    = !s3_valid || ld_res;
  assign ld2    = !s2_valid || ld3;
  assign ld1    = !s1_valid || ld2;

  // Stage 1: row memory data, patched with the most recent write-back.
  always_comb begin
    u_fwd = (wb_valid && (wb_addr == s1_tag.col)) ? wb_data : rd_data;
    u1    = s1_tag.first_row ? LZ3 : u_fwd;
  end

  // Stage 2: delete value and the two halves of the diagonal sum.
  always_comb begin
    dg   = s2_tag.first_cell ? LZ3 : diag;
    p_c  = lse2(dg.m, dg.d);
    q_c  = lse2(dg.i, '0);
    nd_c = lse2(add_lz(s2_u.m, trans_md), add_lz(s2_u.d, trans_dd));
  end

  // Stage 3: match and insert; insert closes the loop on the left neighbor.
  always_comb begin
    lm = s3_tag.first_cell ? VAL_MIN : left.m;
    li = s3_tag.first_cell ? VAL_MIN : left.i;
    ni = lse2(add_lz(lm, trans_mi), add_lz(li, trans_ii));
    nm = (s3_tag.score == VAL_MIN) ? VAL_MIN : add_sat(lse2(s3_p, s3_q), s3_tag.score);
  end

  assign wr_en   = s3_valid && ld_res;
  assign wr_addr = s3_tag.col;
  assign wr_data = '{m: nm, d: s3_nd, i: ni};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
      wb_valid  <= 1'b0;
      diag      <= LZ3;
      left      <= LZ3;
    end else begin
      if (ld1) begin
        s1_valid <= acc;
      end
      if (ld2) begin
        s2_valid <= s1_valid;
      end
      if (ld3) begin
        s3_valid <= s2_valid;
      end
      if (ld_res) begin
        res_valid <= s3_valid;
      end
      if (ld3 && s2_valid) begin
        diag <= s2_tag.last ? LZ3 : s2_u;
      end
      if (wr_en) begin
        wb_valid <= 1'b1;
        left     <= s3_tag.last ? LZ3 : '{m: nm, d: VAL_MIN, i: ni};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_tag <= acc_tag;
    end
    if (ld2) begin
      s2_tag <= s1_tag;
      s2_u   <= u1;
    end
    if (ld3) begin
      s3_tag <= s2_tag;
      s3_p   <= p_c;
      s3_q   <= q_c;
      s3_nd  <= nd_c;
    end
    if (wr_en) begin
      wb_addr <= wr_addr;
      wb_data <= wr_data;
      res     <= '{fwd: wr_data, last: s3_tag.last};
    end
  end

  assign status = '{
    ld1:      ld1,
    s1_valid: s1_valid,
    s1_col:   s1_tag.col,
    s2_valid: s2_valid,
    s2_col:   s2_tag.col,
    s3_valid: s3_valid,
    s3_col:   s3_tag.col,
    s3_leave: ld_res
  };

endmodule

### rtl/log_space_pair_forward_dp.sv
// Local three-state pair forward recurrence in log space, one matrix cell per
// request, cells streamed in row-major order.
// Input stream: s_axis_tdata carries the cell's match score; s_axis_tuser marks
// the first cell of a new matrix. Output stream: one request per cell carrying
// the forward match, delete and insert values, with m_axis_tlast on the last
// column of each row. Configuration requests on the cfg channel set the row
// length and the four log transitions; they are always accepted and are meant
// to arrive only while no cell is in flight.
// An accepted cell passes the pipeline stages and the output register before
// m_axis_tvalid. With a row length of three or more a cell is accepted every
// cycle unless the receiver stalls. Shorter rows make a cell read a memory entry
// that a cell still in the pipeline has yet to write, and the input waits
// for that write. The registered memory read and the pipeline depth cause this.
// A synchronous reset empties the pipeline and the output register, restarts
// at row one, column one, and restores the register defaults. The row memory
// is not cleared; the first row ignores what it reads.
// When the receiver stalls, the result holds in the output register while the
// stages behind it keep filling; the input stalls once all of them are full.
module log_space_pair_forward_dp
  import lspfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input cell stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [19:0] match_score, rest zero
  input  logic                  s_axis_tuser,   // [0] first_cell
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [19:0] fwd_match, [39:20] fwd_delete,
                                                // [59:40] fwd_insert, rest zero
  output logic                  m_axis_tlast,   // row_end
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0] col_count;
  trans_t           trans_md, trans_dd, trans_mi, trans_ii;

  col_t             col_index;
  logic             first_row;

  col_t             j;
  logic             fr_eff;
  logic [CMP_W-1:0] cnt_eff;
  logic [CMP_W-1:0] col_count_ext;
  logic             last;
  logic             hazard;
  logic             accept;
  cell_tag_t        tag;

  pipe_status_t     status;
  triple_t          rd_data;
  logic             wr_en;
  col_t             wr_addr;
  triple_t          wr_data;
  logic             res_valid;
  result_t          res;

  // Configuration registers. Writes are taken every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= CNT_W'(1);
      trans_md  <= '0;
      trans_dd  <= '0;
      trans_mi  <= '0;
      trans_ii  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COL_COUNT: col_count <= cfg_data[CNT_W-1:0];
        REG_TRANS_MD:  trans_md  <= trans_t'(cfg_data);
        REG_TRANS_DD:  trans_dd  <= trans_t'(cfg_data);
        REG_TRANS_MI:  trans_mi  <= trans_t'(cfg_data);
        REG_TRANS_II:  trans_ii  <= trans_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Column sequencing. A first-cell marker restarts at row one, column one.
  // The row length is clamped to the range the row memory holds.
  always_comb begin
    j             = s_axis_tuser ? '0 : col_index;
    fr_eff        = s_axis_tuser ? 1'b1 : first_row;
    col_count_ext = CMP_W'(col_count);
    if (col_count_ext == '0) begin
      cnt_eff = CMP_W'(1);
    end else if (col_count_ext > CMP_W'(MAX_COLS)) begin
      cnt_eff = CMP_W'(MAX_COLS);
    end else begin
      cnt_eff = col_count_ext;
    end
    last = (CMP_W'(j) + CMP_W'(1)) >= cnt_eff;
  end

  // Read-after-write interlock: a cell that needs the row above waits while
  // an older cell for the same column has not yet written its result. A
  // write landing in this very cycle is covered by the write-back bypass.
  always_comb begin
    hazard = !fr_eff && (
             (status.s1_valid && (status.s1_col == j)) ||
             (status.s2_valid && (status.s2_col == j)) ||
             (status.s3_valid && (status.s3_col == j) && !status.s3_leave));
  end

  assign s_axis_tready = status.ld1 && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      if (last) begin
        col_index <= '0;
        first_row <= 1'b0;
      end else begin
        col_index <= j + col_t'(1);
        first_row <= fr_eff;
      end
    end
  end

  assign tag = '{
    col:        j,
    first_row:  fr_eff,
    first_cell: s_axis_tuser,
    last:       last,
    score:      score_t'(s_axis_tdata[SCORE_BITS-1:0])
  };

  lspfd_row_mem u_row_mem (
    .clk     (clk),
    .rd_en   (status.ld1),
    .rd_addr (j),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lspfd_cell_pipe u_cell_pipe (
    .clk       (clk),
    .rst       (rst),
    .acc       (accept),
    .acc_tag   (tag),
    .rd_data   (rd_data),
    .trans_md  (trans_md),
    .trans_dd  (trans_dd),
    .trans_mi  (trans_mi),
    .trans_ii  (trans_ii),
    .res_ready (m_axis_tready),
    .status    (status),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = M_TDATA_W'({res.fwd.i, res.fwd.d, res.fwd.m});
  assign m_axis_tlast  = res.last;

endmodule

### rtl/lspfd_checker.sv
module lspfd_checker
  import lspfd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Cells accepted but not yet delivered; the block holds at most four.
  logic [2:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (inflight != 3'd0))
    else $error("result delivered without an accepted cell");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd4)
    else $error("more cells in flight than the pipeline holds");

endmodule

bind log_space_pair_forward_dp lspfd_checker u_lspfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
